// ===== rtl/sabb_pkg.sv =====
// Shared types, codes and constants of the sequence-addressed byte buffer.
`timescale 1ns / 1ps

package sabb_pkg;

  localparam int CAPACITY_DEF    = 4096;
  localparam int MAX_READ_DEF    = 64;
  localparam int WRITE_BYTES_DEF = 8;

  localparam int SEQ_W    = 32;
  localparam int WORD_W   = 64;
  localparam int BCNT_W   = 4;
  localparam int RLEN_W   = 7;
  localparam int STATUS_W = 3;
  localparam int AVAIL_W  = 13;
  localparam int BYTE_W   = 8;
  localparam int OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_CONSUME = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_BEFORE = 3'd2,
    ST_BEYOND = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    AV_ZERO  = 2'd0,
    AV_COUNT = 2'd1,
    AV_SPAN  = 2'd2
  } avail_sel_t;

  typedef struct packed {
    logic       capture;
    logic       cfg_load;
    logic       eval;
    logic       write_byte;
    logic       consume;
    logic       rd_start;
    logic       rd_issue;
    logic       rd_send;
    logic       post;
    status_t    post_status;
    avail_sel_t post_sel;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic before_start;
    logic at_end;
    logic beyond_end;
    logic full;
    logic no_bytes;
    logic no_len;
    logic wr_last;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/sequence_addressed_byte_buffer_core.sv =====
// Top level of the sequence-addressed byte buffer: controller plus datapath.
`timescale 1ns / 1ps

// Byte buffer addressed by 32-bit stream sequence number, kept as a ring of
// CAPACITY bytes in a single-port memory. One item is worked on at a time.
// An item is taken, its sequence number is range-checked against the start
// and end of the stored data, and its result is posted; a read that returns
// bytes posts one result per byte instead. An accepted write writes its bytes
// into the memory one at a time. A read first sets up its start address and
// length, then for each byte does a registered memory read and loads the
// output register, waiting while it still holds an unaccepted result. The
// result register lets a new item be taken while the last result waits.
// Writing initial_sequence empties the buffer; no clearing pass is needed
// after reset, since a byte is never read before it has been written.

module sequence_addressed_byte_buffer_core #(
  parameter int CAPACITY    = sabb_pkg::CAPACITY_DEF,
  parameter int MAX_READ    = sabb_pkg::MAX_READ_DEF,
  parameter int WRITE_BYTES = sabb_pkg::WRITE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sabb_pkg::OP_W-1:0]     operation,
  input  logic [sabb_pkg::WORD_W-1:0]   data_word,
  input  logic [sabb_pkg::BCNT_W-1:0]   byte_count,
  input  logic [sabb_pkg::SEQ_W-1:0]    seq_number,
  input  logic [sabb_pkg::RLEN_W-1:0]   read_len,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sabb_pkg::STATUS_W-1:0] status,
  output logic [sabb_pkg::BYTE_W-1:0]   data_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic [sabb_pkg::AVAIL_W-1:0]  available,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sabb_pkg::SEQ_W-1:0]    initial_sequence
);
  import sabb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sabb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sabb_dpath #(
    .CAPACITY    (CAPACITY),
    .MAX_READ    (MAX_READ),
    .WRITE_BYTES (WRITE_BYTES)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .data_word        (data_word),
    .byte_count       (byte_count),
    .seq_number       (seq_number),
    .read_len         (read_len),
    .initial_sequence (initial_sequence),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .data_byte        (data_byte),
    .byte_valid       (byte_valid),
    .last             (last),
    .available        (available)
  );

endmodule

// ===== rtl/sabb_ctrl.sv =====
// Controller state machine of the sequence-addressed byte buffer.
`timescale 1ns / 1ps

module sabb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  sabb_pkg::dp_stat_t stat,
  output sabb_pkg::dp_cmd_t  cmd
);
  import sabb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EVAL   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_WRITE  = 8'b0000_1000,
    S_RSTART = 8'b0001_0000,
    S_RREAD  = 8'b0010_0000,
    S_RSEND  = 8'b0100_0000,
    S_POST   = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  status_t    post_status, post_status_next;
  avail_sel_t post_sel, post_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      post_status <= ST_OK;
      post_sel    <= AV_ZERO;
    end else begin
      state       <= state_next;
      post_status <= post_status_next;
      post_sel    <= post_sel_next;
    end
  end

  always_comb begin
    state_next       = state;
    post_status_next = post_status;
    post_sel_next    = post_sel;
    cmd              = '0;
    cmd.post_status  = post_status;
    cmd.post_sel     = post_sel;
    in_ready         = 1'b0;
    cfg_ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        // A register write wins over an item offered in the same cycle.
        cfg_ready    = 1'b1;
        in_ready     = !cfg_valid;
        cmd.cfg_load = cfg_valid;
        cmd.capture  = in_valid && !cfg_valid;
        if (cmd.capture) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_POST;
        unique case (stat.op)
          OP_WRITE: begin
            post_sel_next = AV_COUNT;
            if (stat.full) begin
              post_status_next = ST_FULL;
            end else begin
              post_status_next = ST_OK;
              if (!stat.no_bytes) begin
                state_next = S_WRITE;
              end
            end
          end
          OP_READ: begin
            post_sel_next = AV_ZERO;
            if (stat.before_start) begin
              post_status_next = ST_BEFORE;
            end else if (stat.at_end) begin
              post_status_next = ST_EMPTY;
            end else begin
              post_status_next = ST_OK;
              post_sel_next    = AV_SPAN;
              if (!stat.no_len) begin
                state_next = S_RSTART;
              end
            end
          end
          OP_CONSUME: begin
            post_sel_next = AV_COUNT;
            if (stat.before_start) begin
              post_status_next = ST_BEFORE;
            end else if (stat.beyond_end) begin
              post_status_next = ST_BEYOND;
            end else begin
              post_status_next = ST_OK;
              cmd.consume      = 1'b1;
            end
          end
          OP_QUERY: begin
            if (stat.before_start) begin
              post_status_next = ST_BEFORE;
              post_sel_next    = AV_ZERO;
            end else begin
              post_status_next = ST_OK;
              post_sel_next    = stat.at_end ? AV_ZERO : AV_SPAN;
            end
          end
        endcase
      end
      S_WRITE: begin
        cmd.write_byte = 1'b1;
        if (stat.wr_last) begin
          state_next = S_POST;
        end
      end
      S_RSTART: begin
        cmd.rd_start = 1'b1;
        state_next   = S_RREAD;
      end
      S_RREAD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RSEND;
      end
      S_RSEND: begin
        if (stat.out_free) begin
          cmd.rd_send = 1'b1;
          state_next  = stat.rd_last ? S_IDLE : S_RREAD;
        end
      end
      S_POST: begin
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sabb_dpath.sv =====
// Datapath of the sequence-addressed byte buffer: pointers, ring memory, output register.
`timescale 1ns / 1ps

module sabb_dpath #(
  parameter int CAPACITY    = sabb_pkg::CAPACITY_DEF,
  parameter int MAX_READ    = sabb_pkg::MAX_READ_DEF,
  parameter int WRITE_BYTES = sabb_pkg::WRITE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sabb_pkg::dp_cmd_t             cmd,
  output sabb_pkg::dp_stat_t            stat,
  input  logic [sabb_pkg::OP_W-1:0]     operation,
  input  logic [sabb_pkg::WORD_W-1:0]   data_word,
  input  logic [sabb_pkg::BCNT_W-1:0]   byte_count,
  input  logic [sabb_pkg::SEQ_W-1:0]    seq_number,
  input  logic [sabb_pkg::RLEN_W-1:0]   read_len,
  input  logic [sabb_pkg::SEQ_W-1:0]    initial_sequence,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sabb_pkg::STATUS_W-1:0] status,
  output logic [sabb_pkg::BYTE_W-1:0]   data_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic [sabb_pkg::AVAIL_W-1:0]  available
);
  import sabb_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > RLEN_W) ? CNT_W : RLEN_W;

  function automatic logic [IDX_W-1:0] ring_wrap(input logic [IDX_W:0] sum);
    if (sum >= (IDX_W + 1)'(CAPACITY)) begin
      return IDX_W'(sum - (IDX_W + 1)'(CAPACITY));
    end
    return IDX_W'(sum);
  endfunction

  logic [BYTE_W-1:0] ring_store [CAPACITY];

  // Buffer state.
  logic [SEQ_W-1:0] start_seq;
  logic [SEQ_W:0]   end_seq;
  logic [CNT_W-1:0] stored_count;
  logic [IDX_W-1:0] head_index;

  // Item held while it is worked on.
  op_t               op_r;
  logic [WORD_W-1:0] word_r;
  logic [BCNT_W-1:0] wr_left;
  logic [SEQ_W-1:0]  seq_r;
  logic [RLEN_W-1:0] rlen_r;

  // Results of the range checks.
  logic             before_r, at_end_r, beyond_r, full_r;
  logic [CNT_W-1:0] span_r, offset_r;

  logic [RLEN_W-1:0] remaining;
  logic [IDX_W-1:0]  rptr;
  logic [BYTE_W-1:0] rdata;

  logic [BCNT_W-1:0] n_clamp;
  logic [RLEN_W-1:0] rlen_clamp;
  logic [IDX_W-1:0]  wslot;

  assign n_clamp    = (byte_count > BCNT_W'(WRITE_BYTES)) ? BCNT_W'(WRITE_BYTES) : byte_count;
  assign rlen_clamp = (read_len > RLEN_W'(MAX_READ)) ? RLEN_W'(MAX_READ) : read_len;
  assign wslot      = ring_wrap((IDX_W + 1)'(head_index) + (IDX_W + 1)'(stored_count));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(operation);
      word_r  <= data_word;
      wr_left <= n_clamp;
      seq_r   <= seq_number;
      rlen_r  <= rlen_clamp;
    end else if (cmd.write_byte) begin
      word_r  <= word_r >> BYTE_W;
      wr_left <= wr_left - BCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      before_r <= seq_r < start_seq;
      at_end_r <= {1'b0, seq_r} >= end_seq;
      beyond_r <= {1'b0, seq_r} > end_seq;
      full_r   <= ({1'b0, stored_count} + (CNT_W + 1)'(wr_left)) > (CNT_W + 1)'(CAPACITY);
      span_r   <= CNT_W'(end_seq - {1'b0, seq_r});
      offset_r <= CNT_W'(seq_r - start_seq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_seq    <= '0;
      end_seq      <= '0;
      stored_count <= '0;
      head_index   <= '0;
    end else if (cmd.cfg_load) begin
      start_seq    <= initial_sequence;
      end_seq      <= {1'b0, initial_sequence};
      stored_count <= '0;
      head_index   <= '0;
    end else if (cmd.write_byte) begin
      end_seq      <= end_seq + (SEQ_W + 1)'(1);
      stored_count <= stored_count + CNT_W'(1);
    end else if (cmd.consume) begin
      // The end stays put; only the oldest bytes are dropped.
      start_seq    <= seq_r;
      stored_count <= stored_count - offset_r;
      head_index   <= ring_wrap((IDX_W + 1)'(head_index) + (IDX_W + 1)'(offset_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      ring_store[wslot] <= word_r[BYTE_W-1:0];
    end
    if (cmd.rd_issue) begin
      rdata <= ring_store[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rptr <= ring_wrap((IDX_W + 1)'(head_index) + (IDX_W + 1)'(offset_r));
      if (CMP_W'(span_r) < CMP_W'(rlen_r)) begin
        remaining <= RLEN_W'(span_r);
      end else begin
        remaining <= rlen_r;
      end
    end else if (cmd.rd_send) begin
      remaining <= remaining - RLEN_W'(1);
      rptr      <= (rptr == IDX_W'(CAPACITY - 1)) ? '0 : rptr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rd_send || cmd.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_send) begin
      status     <= ST_OK;
      data_byte  <= rdata;
      byte_valid <= 1'b1;
      last       <= remaining == RLEN_W'(1);
      available  <= AVAIL_W'(span_r);
    end else if (cmd.post) begin
      status     <= cmd.post_status;
      data_byte  <= '0;
      byte_valid <= 1'b0;
      last       <= 1'b1;
      case (cmd.post_sel)
        AV_COUNT: available <= AVAIL_W'(stored_count);
        AV_SPAN:  available <= AVAIL_W'(span_r);
        default:  available <= '0;
      endcase
    end
  end

  always_comb begin
    stat.op           = op_r;
    stat.before_start = before_r;
    stat.at_end       = at_end_r;
    stat.beyond_end   = beyond_r;
    stat.full         = full_r;
    stat.no_bytes     = wr_left == '0;
    stat.no_len       = rlen_r == '0;
    stat.wr_last      = wr_left == BCNT_W'(1);
    stat.rd_last      = remaining == RLEN_W'(1);
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

// ===== dv/tb.sv =====
// Testbench for the sequence-addressed byte buffer: directed and random items, self-checking.
`timescale 1ns / 1ps

module tb;
  import sabb_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int MAX_READ    = MAX_READ_DEF;
  localparam int WRITE_BYTES = WRITE_BYTES_DEF;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct {
    op_t        op;
    bit [63:0]  word;
    bit [3:0]   nbytes;
    bit [31:0]  seq;
    bit [6:0]   rlen;
  } req_t;

  typedef struct {
    status_t    status;
    bit [7:0]   data;
    bit         bvalid;
    bit         last;
    bit [12:0]  avail;
  } reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  op_t         operation = OP_WRITE;
  logic [63:0] data_word = '0;
  logic [3:0]  byte_count = '0;
  logic [31:0] seq_number = '0;
  logic [6:0]  read_len = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        last;
  logic [12:0] available;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] initial_sequence = '0;

  sequence_addressed_byte_buffer_core u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .data_word        (data_word),
    .byte_count       (byte_count),
    .seq_number       (seq_number),
    .read_len         (read_len),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .data_byte        (data_byte),
    .byte_valid       (byte_valid),
    .last             (last),
    .available        (available),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .initial_sequence (initial_sequence)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Buffer state as the block should hold it.
  bit [7:0]  ring_mem [CAPACITY];
  bit [31:0] buf_start;
  int        buf_count;
  int        buf_head;

  req_t   req_pending [$];
  reply_t reply_due [$];
  req_t   seen_req;

  // Start and count as the stimulus expects them, to aim sequence numbers.
  bit [31:0] gen_start;
  int        gen_count;

  bit in_fire;
  bit all_done;
  bit hold_req;
  int idle_cycles;
  int err_count;

  function automatic void add_reply(status_t s, bit [7:0] d, bit v, bit l, int av);
    reply_t r;
    r.status = s;
    r.data   = d;
    r.bvalid = v;
    r.last   = l;
    r.avail  = av[12:0];
    reply_due.push_back(r);
  endfunction

  function automatic void model_reinit(bit [31:0] v);
    buf_start = v;
    buf_count = 0;
    buf_head  = 0;
  endfunction

  function automatic void model_request(req_t r);
    bit [32:0] tail_seq;
    int span;
    int n;
    int take;
    int off;
    tail_seq = {1'b0, buf_start} + 33'(buf_count);
    if (r.seq < buf_start || {1'b0, r.seq} >= tail_seq) span = 0;
    else span = int'(tail_seq - {1'b0, r.seq});
    case (r.op)
      OP_WRITE: begin
        n = (r.nbytes > WRITE_BYTES) ? WRITE_BYTES : r.nbytes;
        if (buf_count + n > CAPACITY) begin
          add_reply(ST_FULL, 0, 0, 1, buf_count);
        end else begin
          for (int i = 0; i < n; i++) begin
            ring_mem[(buf_head + buf_count) % CAPACITY] = r.word[8*i +: 8];
            buf_count++;
          end
          add_reply(ST_OK, 0, 0, 1, buf_count);
        end
      end
      OP_READ: begin
        n = (r.rlen > MAX_READ) ? MAX_READ : r.rlen;
        if (r.seq < buf_start) begin
          add_reply(ST_BEFORE, 0, 0, 1, 0);
        end else if (span == 0) begin
          add_reply(ST_EMPTY, 0, 0, 1, 0);
        end else if (n == 0) begin
          add_reply(ST_OK, 0, 0, 1, span);
        end else begin
          take = (span < n) ? span : n;
          off = int'(r.seq - buf_start);
          for (int i = 0; i < take; i++)
            add_reply(ST_OK, ring_mem[(buf_head + off + i) % CAPACITY], 1, i == take - 1, span);
        end
      end
      OP_CONSUME: begin
        if (r.seq < buf_start) begin
          add_reply(ST_BEFORE, 0, 0, 1, buf_count);
        end else if ({1'b0, r.seq} > tail_seq) begin
          add_reply(ST_BEYOND, 0, 0, 1, buf_count);
        end else begin
          off = int'(r.seq - buf_start);
          buf_head  = (buf_head + off) % CAPACITY;
          buf_count = buf_count - off;
          buf_start = r.seq;
          add_reply(ST_OK, 0, 0, 1, buf_count);
        end
      end
      OP_QUERY: begin
        if (r.seq < buf_start) add_reply(ST_BEFORE, 0, 0, 1, 0);
        else add_reply(ST_OK, 0, 0, 1, span);
      end
    endcase
  endfunction

  function automatic void cmp_field(string name, bit [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  function automatic void check_reply();
    reply_t e;
    if (reply_due.size() == 0) begin
      $display("%0t: unexpected item, status %0h byte %0h", $time, status, data_byte);
      err_count++;
      return;
    end
    e = reply_due.pop_front();
    cmp_field("status", 13'(e.status), 13'(status));
    cmp_field("data_byte", 13'(e.data), 13'(data_byte));
    cmp_field("byte_valid", 13'(e.bvalid), 13'(byte_valid));
    cmp_field("last", 13'(e.last), 13'(last));
    cmp_field("available", e.avail, available);
  endfunction

  // Sampling side: predicts on accepted items, checks accepted results.
  always @(posedge clk) begin
    if (rst) begin
      model_reinit('0);
      in_fire  = 1'b0;
      all_done = 1'b0;
    end else begin
      in_fire = in_valid && in_ready;
      if (cfg_valid && cfg_ready) model_reinit(initial_sequence);
      if (in_fire) begin
        seen_req.op     = operation;
        seen_req.word   = data_word;
        seen_req.nbytes = byte_count;
        seen_req.seq    = seq_number;
        seen_req.rlen   = read_len;
        model_request(seen_req);
      end
      if (out_valid && out_ready) check_reply();
      if (in_fire || (out_valid && out_ready) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      all_done = (req_pending.size() == 0) && !(in_valid && !in_fire) &&
                 (reply_due.size() == 0);
    end
  end

  // Sender: bursts of random length, random gaps between them.
  int   burst_left;
  int   gap_left;
  req_t next_req;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_pending.size() != 0) begin
        next_req = req_pending.pop_front();
        operation  <= next_req.op;
        data_word  <= next_req.word;
        byte_count <= next_req.nbytes;
        seq_number <= next_req.seq;
        read_len   <= next_req.rlen;
        in_valid   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(20, 60);
          gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: its own stall pattern, plus a long hold-off on request.
  int hold_left;
  int rx_mode;
  int mode_left;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void add_item(op_t op, bit [63:0] w, bit [3:0] nb, bit [31:0] s,
                                   bit [6:0] rl);
    req_t r;
    int n;
    r.op = op;
    r.word = w;
    r.nbytes = nb;
    r.seq = s;
    r.rlen = rl;
    req_pending.push_back(r);
    if (op == OP_WRITE) begin
      n = (nb > WRITE_BYTES) ? WRITE_BYTES : nb;
      if (gen_count + n <= CAPACITY) gen_count += n;
    end else if (op == OP_CONSUME && s >= gen_start &&
                 {1'b0, s} <= {1'b0, gen_start} + 33'(gen_count)) begin
      gen_count -= int'(s - gen_start);
      gen_start = s;
    end
  endfunction

  function automatic bit [31:0] aim_seq();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return gen_start + $urandom_range(0, gen_count);
    if (r == 7) return gen_start - $urandom_range(1, 50);
    return $urandom();
  endfunction

  function automatic void add_random();
    int k;
    bit [63:0] w;
    bit [3:0] nb;
    bit [6:0] rl;
    bit [31:0] s;
    k  = $urandom_range(0, 99);
    w  = {$urandom(), $urandom()};
    nb = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 15);
    rl = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 64) : $urandom_range(0, 127);
    if (k < 45) begin
      add_item(OP_WRITE, w, nb, $urandom(), rl);
    end else if (k < 70) begin
      add_item(OP_READ, w, nb, aim_seq(), rl);
    end else if (k < 85) begin
      case ($urandom_range(0, 9))
        0:       s = gen_start + gen_count + $urandom_range(1, 100);
        1:       s = aim_seq();
        default: s = gen_start + $urandom_range(0, gen_count);
      endcase
      add_item(OP_CONSUME, w, nb, s, rl);
    end else begin
      add_item(OP_QUERY, w, nb, aim_seq(), rl);
    end
  endfunction

  // Waits until every item is taken and every result is back, then lets the
  // block settle.
  task automatic drain();
    @(negedge clk);
    while (!all_done) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(bit [31:0] v);
    @(negedge clk);
    initial_sequence <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    gen_start = v;
    gen_count = 0;
  endtask

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    bit [31:0] s0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gen_start = '0;
    gen_count = 0;

    // Start sequence from reset is zero.
    add_item(OP_READ, 0, 0, 0, 5);
    add_item(OP_QUERY, 0, 0, 0, 0);
    add_item(OP_CONSUME, 0, 0, 0, 0);
    add_item(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 8, 0, 0);
    add_item(OP_WRITE, 64'h0123_4567_89AB_CDEF, 0, 0, 0);
    add_item(OP_WRITE, 64'h8877_6655_4433_2211, 15, 0, 0);
    add_item(OP_WRITE, 64'h0, 1, 0, 0);
    add_item(OP_QUERY, 0, 0, 0, 0);
    add_item(OP_QUERY, 0, 0, 17, 0);
    add_item(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 0);
    add_item(OP_READ, 0, 0, 0, 0);
    add_item(OP_READ, 0, 0, 0, 7'h7F);
    add_item(OP_READ, 0, 0, 17, 3);
    add_item(OP_READ, 0, 0, 3, 1);
    add_item(OP_CONSUME, 0, 0, 18, 0);
    add_item(OP_CONSUME, 0, 0, 5, 0);
    add_item(OP_CONSUME, 0, 0, 0, 0);
    add_item(OP_READ, 0, 0, 4, 9);
    add_item(OP_QUERY, 0, 0, 0, 0);
    add_item(OP_READ, 0, 0, 32'hFFFF_FFFF, 64);
    add_item(OP_CONSUME, 0, 0, 17, 0);
    drain();

    // Stored bytes run past the top of the sequence space.
    write_config(32'hFFFF_FFFF);
    add_item(OP_WRITE, {$urandom(), $urandom()}, 8, 0, 0);
    add_item(OP_WRITE, {$urandom(), $urandom()}, 8, 0, 0);
    add_item(OP_READ, 0, 0, 32'hFFFF_FFFF, 64);
    add_item(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 0);
    add_item(OP_CONSUME, 0, 0, 32'hFFFF_FFFF, 0);
    add_item(OP_QUERY, 0, 0, 0, 0);
    add_item(OP_CONSUME, 0, 0, 0, 0);
    drain();

    // The receiver holds off while the sender keeps offering items, so the
    // block stalls its input; reads then span several written items.
    write_config($urandom_range(0, 32'hFFFF_0000));
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      add_item(OP_WRITE, {$urandom(), $urandom()}, WRITE_BYTES, $urandom(), 0);
    add_item(OP_WRITE, 0, 0, 0, 0);
    add_item(OP_READ, 0, 0, gen_start, 64);
    add_item(OP_QUERY, 0, 0, gen_start + 319, 0);
    add_item(OP_READ, 0, 0, gen_start + 314, 64);
    add_item(OP_CONSUME, 0, 0, gen_start + 300, 0);
    for (int i = 0; i < 4; i++)
      add_item(OP_WRITE, {$urandom(), $urandom()}, WRITE_BYTES, 0, 0);
    add_item(OP_READ, 0, 0, gen_start + 10, 64);
    add_item(OP_READ, 0, 0, gen_start + 40, 64);
    add_item(OP_CONSUME, 0, 0, gen_start + gen_count, 0);
    add_item(OP_READ, 0, 0, gen_start, 64);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       s0 = '0;
        2:       s0 = 32'hFFFF_FF00;
        default: s0 = $urandom();
      endcase
      write_config(s0);
      for (int i = 0; i < 75; i++) begin
        if (ph == 1 && i == 40) hold_req = 1'b1;
        add_random();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (reply_due.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, reply_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sabb_pkg.sv
rtl/sabb_ctrl.sv
rtl/sabb_dpath.sv
rtl/sequence_addressed_byte_buffer_core.sv
dv/tb.sv
